FILE: sv/mbrf_pkg.sv
// ---------------------------------------------------------------------------
// mbrf_pkg: shared types and constants of the read-reply framer
// Register indexes, field widths and the result record.
// ---------------------------------------------------------------------------
package mbrf_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned FUNC_W    = 7;
	localparam int unsigned INDEX_W   = 9;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 2'd1;

	localparam logic [BYTE_W-1:0] SLAVE_ADDRESS_RST = 8'd0;
	localparam logic [FUNC_W-1:0] FUNCTION_CODE_RST = 7'd3;

	// one framed byte as it leaves the block
	typedef struct packed {
		logic [BYTE_W-1:0]  frame_byte;
		logic [INDEX_W-1:0] byte_index;
		logic               first_of_frame;
		logic               last_of_frame;
		logic               exception_reply;
	} result_t;

endpackage

FILE: sv/mbrf_rx_if.sv
// ---------------------------------------------------------------------------
// mbrf_rx_if: received byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ---------------------------------------------------------------------------
interface mbrf_rx_if
	import mbrf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/mbrf_frame_if.sv
// ---------------------------------------------------------------------------
// mbrf_frame_if: framed byte channel
// Valid/ready channel carrying one frame byte with its marks per transfer.
// ---------------------------------------------------------------------------
interface mbrf_frame_if
	import mbrf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  frame_byte;
	logic [INDEX_W-1:0] byte_index;
	logic               first_of_frame;
	logic               last_of_frame;
	logic               exception_reply;

	modport source (output valid, output frame_byte, output byte_index,
		output first_of_frame, output last_of_frame, output exception_reply,
		input ready);
	modport sink (input valid, input frame_byte, input byte_index,
		input first_of_frame, input last_of_frame, input exception_reply,
		output ready);
endinterface

FILE: sv/mbrf_parser.sv
// ---------------------------------------------------------------------------
// mbrf_parser: frame state and per-byte decision
// Holds the framing state and decides for each byte whether it is emitted.
// ---------------------------------------------------------------------------
module mbrf_parser
	import mbrf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] slave_address,
	input  logic [FUNC_W-1:0] function_code,
	output logic              emit,
	output result_t           res
);

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_FUNC  = 2'd1;
	localparam logic [1:0] PH_COUNT = 2'd2;
	localparam logic [1:0] PH_BODY  = 2'd3;

	localparam logic [INDEX_W-1:0] EXC_TAIL  = 9'd3;
	localparam logic [INDEX_W-1:0] CHECK_LEN = 9'd2;

	logic [1:0]         phase_q, phase_d;
	logic [INDEX_W-1:0] remain_q, remain_d;
	logic [INDEX_W-1:0] pos_q, pos_d;
	logic               exc_q, exc_d;

	always_comb begin
		phase_d  = PH_HUNT;
		remain_d = '0;
		pos_d    = '0;
		exc_d    = 1'b0;
		emit     = 1'b0;
		res.frame_byte      = rx_byte;
		res.byte_index      = '0;
		res.first_of_frame  = 1'b0;
		res.last_of_frame   = 1'b0;
		res.exception_reply = 1'b0;
		if (slave_address != '0) begin
			unique case (phase_q)
				PH_FUNC: begin
					if (rx_byte == {1'b0, function_code}) begin
						phase_d  = PH_COUNT;
						pos_d    = 9'd2;
						emit     = 1'b1;
						res.byte_index = 9'd1;
					end else if (rx_byte == {1'b1, function_code}) begin
						phase_d  = PH_BODY;
						remain_d = EXC_TAIL;
						pos_d    = 9'd2;
						exc_d    = 1'b1;
						emit     = 1'b1;
						res.byte_index      = 9'd1;
						res.exception_reply = 1'b1;
					end else if (rx_byte == slave_address) begin
						// a byte that misses the function code but equals the slave address opens a new candidate
						phase_d = PH_FUNC;
						pos_d   = 9'd1;
						emit    = 1'b1;
						res.first_of_frame = 1'b1;
					end
				end
				PH_COUNT: begin
					phase_d  = PH_BODY;
					remain_d = {1'b0, rx_byte} + CHECK_LEN;
					pos_d    = 9'd3;
					exc_d    = exc_q;
					emit     = 1'b1;
					res.byte_index = 9'd2;
				end
				PH_BODY: begin
					emit = 1'b1;
					res.byte_index      = pos_q;
					res.exception_reply = exc_q;
					if (remain_q <= 9'd1) begin
						res.last_of_frame = 1'b1;
					end else begin
						phase_d  = PH_BODY;
						remain_d = remain_q - 9'd1;
						pos_d    = pos_q + 9'd1;
						exc_d    = exc_q;
					end
				end
				default: begin
					if (rx_byte == slave_address) begin
						phase_d = PH_FUNC;
						pos_d   = 9'd1;
						emit    = 1'b1;
						res.first_of_frame = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			remain_q <= '0;
			pos_q    <= '0;
			exc_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			pos_q    <= pos_d;
			exc_q    <= exc_d;
		end
	end

endmodule

FILE: sv/mbrf_out_stage.sv
// ---------------------------------------------------------------------------
// mbrf_out_stage: result register
// Holds one framed byte and drives the outgoing channel.
// ---------------------------------------------------------------------------
module mbrf_out_stage
	import mbrf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  result_t      res,
	output logic         can_load,
	mbrf_frame_if.source frame
);

	logic    valid_q;
	result_t data_q;

	// register is free when empty or being drained this cycle
	assign can_load = !valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && push) begin
			data_q <= res;
		end
	end

	assign frame.valid           = valid_q;
	assign frame.frame_byte      = data_q.frame_byte;
	assign frame.byte_index      = data_q.byte_index;
	assign frame.first_of_frame  = data_q.first_of_frame;
	assign frame.last_of_frame   = data_q.last_of_frame;
	assign frame.exception_reply = data_q.exception_reply;

endmodule

FILE: sv/modbus_rtu_read_response_framer.sv
// ---------------------------------------------------------------------------
// modbus_rtu_read_response_framer: read-reply framer for a serial byte stream
// Picks reply frames of the configured slave out of received bytes and
// forwards each frame byte with its position, first/last marks and an
// exception flag.
// ---------------------------------------------------------------------------
//
//   channel   dir   transfer moves
//   -------   ---   -----------------------------------------------------
//   rx        in    rx_byte
//   frame     out   frame_byte, byte_index, first_of_frame, last_of_frame,
//                   exception_reply
//   cfg       in    cfg_we / cfg_index / cfg_data register write
//
// one byte per cycle sustained while frame takes its bytes; a framed byte
// appears on frame the cycle after its rx transfer, via the single result register
// hunting bytes are consumed with no output transfer
// rx.ready follows the result register: low only while it holds an untaken
// byte and frame.ready is low
// arst_n clears framing state, result valid and the registers to
// slave_address 0 and function_code 3; no clearing pass is needed
// ---------------------------------------------------------------------------
module modbus_rtu_read_response_framer
	import mbrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	mbrf_rx_if.sink              rx,
	mbrf_frame_if.source         frame
);

	logic [BYTE_W-1:0] slave_q;
	logic [FUNC_W-1:0] func_q;
	logic              can_load;
	logic              accept;
	logic              emit;
	result_t           res;

	// configuration registers, to be written only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_ADDRESS_RST;
			func_q  <= FUNCTION_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE_ADDRESS: slave_q <= cfg_data;
				REG_FUNCTION_CODE: func_q  <= cfg_data[FUNC_W-1:0];
				default: ;
			endcase
		end
	end

	// rx is ready whenever the result register can take a byte
	assign rx.ready = can_load;
	assign accept   = rx.valid && can_load;

	mbrf_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (rx.rx_byte),
		.slave_address (slave_q),
		.function_code (func_q),
		.emit          (emit),
		.res           (res)
	);

	mbrf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && emit),
		.res      (res),
		.can_load (can_load),
		.frame    (frame)
	);

	// with framing disabled an accepted byte never produces output
	a_disabled_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && slave_q == '0) |=> !frame.valid)
		else $error("byte emitted while slave address is zero");

	// opening byte sits at position zero and is never flagged as exception
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.first_of_frame) |->
		(frame.byte_index == '0 && !frame.exception_reply && !frame.last_of_frame))
		else $error("bad marks on opening byte");

	// frame position never runs past the longest reply
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |-> frame.byte_index <= 9'd259)
		else $error("byte index out of range");

	// a closing byte is at least the fifth of its frame
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.last_of_frame) |-> frame.byte_index >= 9'd4)
		else $error("frame closed too early");

endmodule
